// ===== sv/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and sizes for the bitset engine: request codes, controller
// states and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

   localparam int CAPACITY_BITS = 1024;
   localparam int WORD_BITS     = 32;
   localparam int NUM_WORDS     = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_ADDR_W   = $clog2(NUM_WORDS);
   localparam int WORD_SHIFT    = $clog2(WORD_BITS);
   localparam int USED_W        = $clog2(NUM_WORDS + 1);
   localparam int LEN_W         = 11;
   localparam int BIT_IDX_W     = 10;
   localparam int POP_W         = $clog2(WORD_BITS + 1);

   typedef enum logic [3:0] {
      OP_SET    = 4'd0,
      OP_GET    = 4'd1,
      OP_CLEAR  = 4'd2,
      OP_INVERT = 4'd3,
      OP_FIND   = 4'd4,
      OP_COUNT  = 4'd5,
      OP_EMPTY  = 4'd6,
      OP_OR     = 4'd7,
      OP_AND    = 4'd8,
      OP_SUB    = 4'd9,
      OP_COPY   = 4'd10,
      OP_EQUAL  = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_TAIL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic rd_en;
      logic clear_all;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic early_done;
      logic is_clear;
      logic scan_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/bse_controller.sv =====
// ----------------------------------------------------------------------------
// bse_controller
// Sequencer for the bitset engine: takes a request word, walks the datapath
// through decode, word reads and the final result load.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bse_pkg::stat_type stat,
   output bse_pkg::cmd_type  cmd
);
   import bse_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      busy          = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_clear) begin
               cmd.clear_all = 1'b1;
               state_in      = ST_FINISH;
            end else if (stat.early_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = stat.scan_last ? ST_TAIL : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            // last word returns and is applied this cycle
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/bse_datapath.sv =====
// ----------------------------------------------------------------------------
// bse_datapath
// Word store, request registers, length tracking, per-word evaluation and
// result registers of the bitset engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [bse_pkg::LEN_W-1:0] csr_write_data,
   input  logic [3:0]                req_type,
   input  logic [bse_pkg::BIT_IDX_W-1:0] req_bit_index,
   input  logic                      req_bit_value,
   input  logic [bse_pkg::WORD_ADDR_W-1:0] req_word_index,
   input  logic [bse_pkg::WORD_BITS-1:0] req_source_word,
   input  bse_pkg::cmd_type          cmd,
   output bse_pkg::stat_type         stat,
   output logic                      rsp_valid,
   output logic                      rsp_status,
   output logic                      rsp_read_bit,
   output logic                      rsp_found,
   output logic [bse_pkg::BIT_IDX_W-1:0] rsp_position,
   output logic [bse_pkg::LEN_W-1:0] rsp_ones_count,
   output logic                      rsp_flag
);
   import bse_pkg::*;

   function automatic logic [POP_W-1:0] popcount32(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] c;
      c = (v & 32'h55555555) + ((v >> 1) & 32'h55555555);
      c = (c & 32'h33333333) + ((c >> 2) & 32'h33333333);
      c = (c & 32'h0F0F0F0F) + ((c >> 4) & 32'h0F0F0F0F);
      c = (c & 32'h00FF00FF) + ((c >> 8) & 32'h00FF00FF);
      c = (c & 32'h0000FFFF) + ((c >> 16) & 32'h0000FFFF);
      return c[POP_W-1:0];
   endfunction

   // request registers
   logic [3:0]             op_ff;
   logic [BIT_IDX_W-1:0]   bit_ff;
   logic                   val_ff;
   logic [WORD_ADDR_W-1:0] widx_ff;
   logic [WORD_BITS-1:0]   src_ff;
   logic [WORD_ADDR_W-1:0] ptr_ff;
   logic [WORD_ADDR_W-1:0] ptr_start;

   // length state
   logic [LEN_W-1:0]       base_ff;
   logic [LEN_W-1:0]       grown_ff;
   logic [LEN_W-1:0]       base_cl;
   logic [LEN_W-1:0]       len;
   logic [LEN_W:0]         len_round;
   logic [USED_W-1:0]      used;
   logic [USED_W-1:0]      used_m1;
   logic [WORD_ADDR_W-1:0] end_ptr;

   // store and read stage
   logic [WORD_BITS-1:0]   mem [NUM_WORDS];
   logic [NUM_WORDS-1:0]   valid_ff;
   logic [WORD_BITS-1:0]   rd_data_ff;
   logic                   rd_vld_ff;
   logic [WORD_ADDR_W-1:0] rd_addr_ff;
   logic                   pend_ff;
   logic [WORD_BITS-1:0]   word;
   logic                   wr_en;
   logic [WORD_BITS-1:0]   wr_data;
   logic [WORD_BITS-1:0]   bit_mask;

   // find
   logic [WORD_BITS-1:0]   low_mask;
   logic [WORD_BITS-1:0]   len_mask;
   logic [WORD_BITS-1:0]   hit_bits;
   logic [WORD_SHIFT-1:0]  hit_idx;
   logic [USED_W-1:0]      len_word;

   // accumulators
   logic                   rbit_ff;
   logic                   found_ff;
   logic [BIT_IDX_W-1:0]   pos_ff;
   logic [LEN_W-1:0]       cnt_ff;
   logic                   nz_ff;
   logic                   eq_ff;

   // early decisions
   logic                   is_word_op;
   logic                   bit_past_len;
   logic                   refuse;
   logic                   skip;

   // result registers
   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic                   rsp_read_bit_ff;
   logic                   rsp_found_ff;
   logic [BIT_IDX_W-1:0]   rsp_position_ff;
   logic [LEN_W-1:0]       rsp_ones_count_ff;
   logic                   rsp_flag_ff;

   // effective length and words in use
   always_comb begin
      base_cl   = (base_ff > LEN_W'(CAPACITY_BITS)) ? LEN_W'(CAPACITY_BITS) : base_ff;
      len       = (base_cl > grown_ff) ? base_cl : grown_ff;
      len_round = {1'b0, len} + (LEN_W+1)'(WORD_BITS - 1);
      used      = USED_W'(len_round >> WORD_SHIFT);
      used_m1   = used - USED_W'(1);
      len_word  = USED_W'(len >> WORD_SHIFT);
   end

   always_comb begin
      unique case (req_type)
         OP_SET, OP_GET, OP_FIND:
            ptr_start = req_bit_index[BIT_IDX_W-1:WORD_SHIFT];
         OP_OR, OP_AND, OP_SUB, OP_COPY, OP_EQUAL:
            ptr_start = req_word_index;
         default:
            ptr_start = '0;
      endcase
   end

   always_comb begin
      unique case (op_ff)
         OP_INVERT, OP_FIND: end_ptr = used_m1[WORD_ADDR_W-1:0];
         OP_COUNT, OP_EMPTY: end_ptr = WORD_ADDR_W'(NUM_WORDS - 1);
         default:            end_ptr = ptr_ff;
      endcase
   end

   always_comb begin
      is_word_op   = (op_ff >= OP_OR) && (op_ff <= OP_EQUAL);
      bit_past_len = {1'b0, bit_ff} >= len;
      refuse = (op_ff > OP_EQUAL)
             || ((op_ff == OP_SET) && ({1'b0, bit_ff} >= LEN_W'(CAPACITY_BITS)))
             || ((op_ff == OP_GET) && bit_past_len)
             || (is_word_op && ({1'b0, widx_ff} >= used));
      skip   = ((op_ff == OP_FIND) && bit_past_len)
             || ((op_ff == OP_INVERT) && (used == '0));
      stat.early_done = refuse || skip;
      stat.is_clear   = (op_ff == OP_CLEAR);
      stat.scan_last  = (ptr_ff == end_ptr);
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= LEN_W'(CAPACITY_BITS);
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   // capture the request, advance the read pointer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_type;
         bit_ff  <= req_bit_index;
         val_ff  <= req_bit_value;
         widx_ff <= req_word_index;
         src_ff  <= req_source_word;
         ptr_ff  <= ptr_start;
      end else if (cmd.rd_en) begin
         ptr_ff  <= ptr_ff + WORD_ADDR_W'(1);
      end
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_addr_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[ptr_ff];
         rd_vld_ff  <= valid_ff[ptr_ff];
         rd_addr_ff <= ptr_ff;
      end
   end

   // a word never written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_en;
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[rd_addr_ff] <= 1'b1;
         end
      end
   end

   // apply the returned word
   always_comb begin
      word     = rd_vld_ff ? rd_data_ff : '0;
      bit_mask = WORD_BITS'(1) << bit_ff[WORD_SHIFT-1:0];
      wr_en    = 1'b0;
      wr_data  = word;
      if (pend_ff) begin
         case (op_ff)
            OP_SET: begin
               wr_en   = 1'b1;
               wr_data = val_ff ? (word | bit_mask) : (word & ~bit_mask);
            end
            OP_INVERT: begin
               wr_en   = 1'b1;
               wr_data = ~word;
            end
            OP_OR: begin
               wr_en   = 1'b1;
               wr_data = word | src_ff;
            end
            OP_AND: begin
               wr_en   = 1'b1;
               wr_data = word & src_ff;
            end
            OP_SUB: begin
               wr_en   = 1'b1;
               wr_data = word & ~src_ff;
            end
            OP_COPY: begin
               wr_en   = 1'b1;
               wr_data = src_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // find: mask off bits before the start and at or past the length
   always_comb begin
      low_mask = (rd_addr_ff == bit_ff[BIT_IDX_W-1:WORD_SHIFT])
               ? ({WORD_BITS{1'b1}} << bit_ff[WORD_SHIFT-1:0]) : {WORD_BITS{1'b1}};
      if ({1'b0, rd_addr_ff} < len_word) begin
         len_mask = {WORD_BITS{1'b1}};
      end else if ({1'b0, rd_addr_ff} == len_word) begin
         len_mask = ~({WORD_BITS{1'b1}} << len[WORD_SHIFT-1:0]);
      end else begin
         len_mask = '0;
      end
      hit_bits = word & low_mask & len_mask;
      hit_idx  = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (hit_bits[i]) begin
            hit_idx = WORD_SHIFT'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rbit_ff  <= 1'b0;
         found_ff <= 1'b0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         nz_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else if (pend_ff) begin
         case (op_ff)
            OP_GET:   rbit_ff <= word[bit_ff[WORD_SHIFT-1:0]];
            OP_FIND: begin
               if (!found_ff && (hit_bits != '0)) begin
                  found_ff <= 1'b1;
                  pos_ff   <= {rd_addr_ff, hit_idx};
               end
            end
            OP_COUNT: cnt_ff <= cnt_ff + LEN_W'(popcount32(word));
            OP_EMPTY: nz_ff  <= nz_ff | (word != '0);
            OP_EQUAL: eq_ff  <= (word == src_ff);
            default:  eq_ff  <= eq_ff;
         endcase
      end
   end

   // grow the length on a set at or past it
   always_ff @(posedge clock) begin
      if (reset) begin
         grown_ff <= '0;
      end else if (pend_ff && (op_ff == OP_SET) && bit_past_len) begin
         grown_ff <= {1'b0, bit_ff} + LEN_W'(1);
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff     <= refuse;
         rsp_read_bit_ff   <= rbit_ff;
         rsp_found_ff      <= found_ff;
         rsp_position_ff   <= pos_ff;
         rsp_ones_count_ff <= cnt_ff;
         rsp_flag_ff       <= (op_ff == OP_EMPTY) ? ~nz_ff : eq_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_bit   = rsp_read_bit_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_ones_count = rsp_ones_count_ff;
   assign rsp_flag       = rsp_flag_ff;

endmodule

`default_nettype wire

// ===== sv/bitset_engine.sv =====
// ----------------------------------------------------------------------------
// bitset_engine
// A 1024-bit set held as 32 words of 32 bits, with bit set and read, clear,
// invert, find-next-set, popcount, empty test and word-wise source operations.
// ----------------------------------------------------------------------------
// Use:
//   Drive the request fields and raise start while busy is low; the word is
//   taken at that edge and busy rises until the result has been loaded.
//   Each request gives one result word, shown for a single cycle with
//   rsp_valid high. The receiver cannot stall: take it in that cycle.
//   Steps: capture, decode, the word reads, applying the last word and
//   loading the result; the result shows the cycle after that. Words read:
//     refused, skipped or clear-all requests: no word is read
//     set, get and word operations:            one word
//     invert and find: the words walked (up to 32)
//     count and empty: always every stored word
//   A new start is taken in the cycle rsp_valid is shown. The walk over the
//   word store reads one word a cycle.
//   Reset clears the store (a valid bit per word; unwritten words read zero),
//   the grown length, and sets the base length to 1024. Write the base
//   length only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module bitset_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [3:0]                       req_type,
   input  logic [bse_pkg::BIT_IDX_W-1:0]    req_bit_index,
   input  logic                             req_bit_value,
   input  logic [bse_pkg::WORD_ADDR_W-1:0]  req_word_index,
   input  logic [bse_pkg::WORD_BITS-1:0]    req_source_word,
   input  logic                             csr_write_enable,
   input  logic [bse_pkg::LEN_W-1:0]        csr_write_data,
   output logic                             rsp_valid,
   output logic                             rsp_status,
   output logic                             rsp_read_bit,
   output logic                             rsp_found,
   output logic [bse_pkg::BIT_IDX_W-1:0]    rsp_position,
   output logic [bse_pkg::LEN_W-1:0]        rsp_ones_count,
   output logic                             rsp_flag
);
   import bse_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: decode, walk the words, load the result
   bse_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // store, length tracking, per-word evaluation and result registers
   bse_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_type         (req_type),
      .req_bit_index    (req_bit_index),
      .req_bit_value    (req_bit_value),
      .req_word_index   (req_word_index),
      .req_source_word  (req_source_word),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_read_bit     (rsp_read_bit),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .rsp_ones_count   (rsp_ones_count),
      .rsp_flag         (rsp_flag)
   );

endmodule

`default_nettype wire
